[sv/b64d_pkg.sv]
// Package for the base64 stream decoder.
// Holds the character constants, the alphabet lookup and the byte bundle type.
// Used by b64d_unit, b64d_ser and base64_stream_decoder; depends on nothing.
package b64d_pkg;

  // The padding character.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Sextet values shared by several alphabet characters.
  localparam logic [5:0] SEXTET_62 = 6'd62;
  localparam logic [5:0] SEXTET_63 = 6'd63;

  // Most bytes that one character can produce.
  localparam int unsigned MAX_BYTES = 3;

  // Bytes produced by one character, first byte in slot 0.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                count;
    logic                      msg_end;
  } bundle_t;

  // Map one character to its 6-bit value; unknown characters, pad included, give 0.
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [5:0] v;
    v = '0;
    unique case (c) inside
      [8'h41:8'h5A]:             v = 6'(c - 8'h41);
      [8'h61:8'h7A]:             v = 6'(c - 8'd71);
      [8'h30:8'h39]:             v = 6'(c + 8'd4);
      8'h2B, 8'h2D, 8'h2E:       v = SEXTET_62;
      8'h2F, 8'h2C, 8'h5F:       v = SEXTET_63;
      default:                   v = '0;
    endcase
    return v;
  endfunction

endpackage

[sv/b64d_unit.sv]
// Input register, group state and decode logic of the base64 stream decoder.
// Turns each character into a bundle of zero to three bytes.
// Depends on b64d_pkg.
module b64d_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_char_code,
  input  logic                in_message_last,
  input  logic                ser_ready,
  output logic                bundle_valid,
  output b64d_pkg::bundle_t   bundle
);

  logic        in_vld_r;
  logic [7:0]  char_r;
  logic        last_r;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        tpad_r, tpad_nxt;
  logic [5:0]  v;
  logic [23:0] w;
  logic        is_pad;
  logic        adv;

  // Decode the held character against the group state.
  always_comb begin
    v        = b64d_pkg::sextet_of(char_r);
    is_pad   = (char_r == b64d_pkg::PAD_CHAR);
    w        = {acc_r, v};
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    tpad_nxt = tpad_r;
    bundle   = '0;
    if (!last_r) begin
      if (pos_r != 2'd3) begin
        acc_nxt = {acc_r[11:0], v};
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd2) begin
          tpad_nxt = is_pad;
        end
      end else begin
        bundle.bytes[0] = w[23:16];
        bundle.bytes[1] = w[15:8];
        bundle.bytes[2] = w[7:0];
        bundle.count    = 2'd3;
        acc_nxt         = '0;
        pos_nxt         = '0;
        tpad_nxt        = 1'b0;
      end
    end else begin
      bundle.msg_end = 1'b1;
      acc_nxt        = '0;
      pos_nxt        = '0;
      tpad_nxt       = 1'b0;
      case (pos_r)
        2'd0: begin
          bundle.bytes[0] = {v, 2'b00};
          bundle.count    = 2'd1;
        end
        2'd1: begin
          bundle.bytes[0] = {acc_r[5:0], v[5:4]};
          bundle.count    = 2'd1;
        end
        2'd2: begin
          bundle.bytes[0] = acc_r[11:4];
          bundle.bytes[1] = {acc_r[3:0], v[5:2]};
          bundle.count    = is_pad ? 2'd1 : 2'd2;
        end
        default: begin
          if (is_pad) begin
            bundle.bytes[0] = acc_r[17:10];
            bundle.bytes[1] = acc_r[9:2];
            bundle.count    = tpad_r ? 2'd1 : 2'd2;
          end else begin
            bundle.bytes[0] = w[23:16];
            bundle.bytes[1] = w[15:8];
            bundle.bytes[2] = w[7:0];
            bundle.count    = 2'd3;
          end
        end
      endcase
    end
  end

  // The held character moves on when it yields nothing or the serializer has room.
  assign adv          = in_vld_r && ((bundle.count == 2'd0) || ser_ready);
  assign bundle_valid = in_vld_r && (bundle.count != 2'd0);
  assign in_stall     = in_vld_r && !adv;

  // Input register control and group state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      acc_r    <= '0;
      pos_r    <= '0;
      tpad_r   <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        acc_r  <= acc_nxt;
        pos_r  <= pos_nxt;
        tpad_r <= tpad_nxt;
      end
    end
  end

  // Input payload is captured on each transfer.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_code;
      last_r <= in_message_last;
    end
  end

endmodule

[sv/b64d_ser.sv]
// Output serializer of the base64 stream decoder.
// Holds one bundle and presents its bytes one per transfer.
// Depends on b64d_pkg.
module b64d_ser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bundle_valid,
  input  b64d_pkg::bundle_t   bundle,
  output logic                ser_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_data_byte,
  output logic                out_run_last,
  output logic                out_message_end
);

  logic                                vld_r;
  logic [b64d_pkg::MAX_BYTES-1:0][7:0] bytes_r;
  logic [1:0]                          rem_r;
  logic                                end_r;
  logic                                load;

  // Room for a new bundle once the last byte of the current one goes out.
  assign ser_ready = !vld_r || ((rem_r == 2'd1) && !out_stall);
  assign load      = bundle_valid && ser_ready;

  // Valid and remaining-byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rem_r <= '0;
    end else if (load) begin
      vld_r <= 1'b1;
      rem_r <= bundle.count;
    end else if (vld_r && !out_stall) begin
      if (rem_r == 2'd1) begin
        vld_r <= 1'b0;
      end
      rem_r <= rem_r - 2'd1;
    end
  end

  // Byte shift line; slot 0 is always the byte on offer.
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= bundle.bytes;
      end_r   <= bundle.msg_end;
    end else if (vld_r && !out_stall) begin
      bytes_r[0] <= bytes_r[1];
      bytes_r[1] <= bytes_r[2];
    end
  end

  assign out_valid       = vld_r;
  assign out_data_byte   = bytes_r[0];
  assign out_run_last    = (rem_r == 2'd1);
  assign out_message_end = end_r && (rem_r == 2'd1);

endmodule

[sv/base64_stream_decoder.sv]
// Top level of the base64 stream decoder.
// Instantiates b64d_unit and b64d_ser; depends on b64d_pkg.
//
// Usage:
//   Input channel: one character per transfer (in_char_code) with
//   in_message_last marking the final character of a message. Output
//   channel: one decoded byte per transfer, with out_run_last on the last
//   byte caused by one character and out_message_end on the final byte of
//   the message. Both channels transfer when valid is high and stall low.
//   A character is held and decoded in the input register; the serializer
//   register then offers its bytes, one per cycle while the receiver does
//   not stall. Throughput: one character per cycle; the input stalls only
//   while a character that yields bytes waits for the last byte of the
//   previous bundle to transfer. A full group of four characters yields
//   three bytes, so an unbroken stream of full groups runs at one
//   character per cycle while the receiver does not stall.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   group state. When the receiver stalls, the offered byte holds, and the
//   input stalls once the input register holds a character that yields bytes.
module base64_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_message_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_run_last,
  output logic       out_message_end
);

  logic              bundle_valid;
  logic              ser_ready;
  b64d_pkg::bundle_t bundle;

  // Character decode and group state.
  b64d_unit u_unit (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_message_last (in_message_last),
    .ser_ready       (ser_ready),
    .bundle_valid    (bundle_valid),
    .bundle          (bundle)
  );

  // Byte serializer and output register.
  b64d_ser u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .bundle_valid    (bundle_valid),
    .bundle          (bundle),
    .ser_ready       (ser_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for base64_stream_decoder: directed and random character streams.
// A local decoder model predicts every byte and its flags; uses b64d_pkg for the pad code.
module tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-.,_";

  typedef struct {
    logic [7:0] data_byte;
    logic       run_last;
    logic       message_end;
  } decoded_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_code = 8'h00;
  logic       in_message_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_run_last;
  logic       out_message_end;

  // Decoder state as the bench sees it.
  logic [17:0] group_sextets = '0;
  logic [1:0]  group_count = '0;
  logic        third_is_pad = 1'b0;

  decoded_byte_t expected_bytes[$];
  int unsigned   chars_sent = 0;
  int unsigned   bytes_checked = 0;
  int unsigned   messages_sent = 0;
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            sender_idles = 1'b0;
  logic          receiver_stalls = 1'b0;
  int unsigned   stall_hold = 0;

  base64_stream_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_code    (in_char_code),
    .in_message_last (in_message_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

  always #5 clk = ~clk;

  // The run is cut off if it takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still expected", $time, expected_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure comes in bursts of random length.
  always @(posedge clk) begin
    if (!rst_n || !receiver_stalls) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (!out_stall && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_hold <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Every byte transfer is compared with the oldest expected byte.
  always @(posedge clk) begin
    decoded_byte_t exp_byte;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h", $time, out_data_byte);
        error_count++;
      end else begin
        exp_byte = expected_bytes.pop_front();
        bytes_checked++;
        if (out_data_byte !== exp_byte.data_byte) begin
          $display("%0t: data_byte expected %h actual %h", $time,
                   exp_byte.data_byte, out_data_byte);
          error_count++;
        end
        if (out_run_last !== exp_byte.run_last) begin
          $display("%0t: run_last expected %b actual %b", $time,
                   exp_byte.run_last, out_run_last);
          error_count++;
        end
        if (out_message_end !== exp_byte.message_end) begin
          $display("%0t: message_end expected %b actual %b", $time,
                   exp_byte.message_end, out_message_end);
          error_count++;
        end
      end
    end
  end

  // Six-bit value of one character; anything outside the alphabet decodes as zero.
  function automatic logic [5:0] char_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - "A");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
    if (c == "+" || c == "-" || c == ".") return 6'd62;
    if (c == "/" || c == "," || c == "_") return 6'd63;
    return 6'd0;
  endfunction

  // Work out the bytes that one accepted character releases.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [5:0]  v;
    logic [23:0] word;
    logic [7:0]  out_bytes[3];
    int          n;
    decoded_byte_t item;
    v = char_value(c);
    word = {group_sextets, v};
    n = 0;
    if (!last) begin
      if (group_count != 2'd3) begin
        if (group_count == 2'd2) third_is_pad = (c == b64d_pkg::PAD_CHAR);
        group_sextets = {group_sextets[11:0], v};
        group_count = group_count + 2'd1;
        return;
      end
      out_bytes = '{word[23:16], word[15:8], word[7:0]};
      n = 3;
    end else begin
      case (group_count)
        2'd0: begin
          out_bytes[0] = {v, 2'b00};
          n = 1;
        end
        2'd1: begin
          out_bytes[0] = {group_sextets[5:0], v[5:4]};
          n = 1;
        end
        2'd2: begin
          out_bytes[0] = group_sextets[11:4];
          out_bytes[1] = {group_sextets[3:0], v[5:2]};
          n = (c == b64d_pkg::PAD_CHAR) ? 1 : 2;
        end
        default: begin
          if (c == b64d_pkg::PAD_CHAR) begin
            // A padded fourth character is dropped; a padded third one drops a byte too.
            out_bytes[0] = group_sextets[17:10];
            out_bytes[1] = group_sextets[9:2];
            n = third_is_pad ? 1 : 2;
          end else begin
            out_bytes = '{word[23:16], word[15:8], word[7:0]};
            n = 3;
          end
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      item.data_byte = out_bytes[i];
      item.run_last = (i == n - 1);
      item.message_end = last && (i == n - 1);
      expected_bytes = {expected_bytes, item};
    end
    group_sextets = '0;
    group_count = '0;
    third_is_pad = 1'b0;
  endtask

  // Offer one character, hold it until the transfer, then maybe idle for a burst.
  task automatic send_char(input logic [7:0] c, input logic last);
    in_valid <= 1'b1;
    in_char_code <= c;
    in_message_last <= last;
    do @(posedge clk); while (in_stall);
    decode_char(c, last);
    chars_sent++;
    if (last) messages_sent++;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Send a string as one whole message.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // A message of alphabet characters with some stray bytes and optional padding.
  task automatic send_random_message();
    int         len;
    int         pads;
    logic [7:0] c;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
    pads = 0;
    if (len >= 2 && $urandom_range(0, 2) == 0) pads = (len >= 3) ? $urandom_range(1, 2) : 1;
    for (int i = 0; i < len; i++) begin
      if (i >= len - pads) c = b64d_pkg::PAD_CHAR;
      else if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
      else c = ALPHABET[$urandom_range(0, ALPHABET.len() - 1)];
      send_char(c, i == len - 1);
    end
  endtask

  // Alphabet extremes, the alternate symbols and every way a message can end.
  task automatic test_directed_groups();
    send_text("AZaz09+/");
    send_text(",_==");
    send_text("-._=");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char("9", 1'b1);
    send_text("z+=");
    send_text("/AQ");
  endtask

  // Random messages with idling on both sides, switched per message.
  task automatic test_random_messages();
    while (chars_sent < 220) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_stalls <= ($urandom_range(0, 3) != 0);
      send_random_message();
    end
  endtask

  // The last stretch runs at full rate with no idling on either side.
  task automatic test_full_rate();
    sender_idles = 1'b0;
    receiver_stalls <= 1'b0;
    while (chars_sent < 250) send_random_message();
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_groups();
    test_random_messages();
    test_full_rate();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Decoded %0d characters in %0d messages; %0d bytes compared.",
             chars_sent, messages_sent, bytes_checked);
    $display("Covered every group ending, padding, stray bytes, idling and stalls.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[base64_stream_decoder.f]
sv/b64d_pkg.sv
sv/b64d_unit.sv
sv/b64d_ser.sv
sv/base64_stream_decoder.sv
bench/tb.sv
